// ----- design/nbag_pkg.sv -----
`default_nettype none
package nbag_pkg;
    localparam int unsigned EXT_W = 32;
    localparam int unsigned STR_W = 40;
    localparam int unsigned LIN_W = 48;
    localparam int unsigned OUT_W = 48;
    localparam int unsigned RANK_W = 4;
    localparam int unsigned OP_W = 2;
    localparam int unsigned DIM_W = 3;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_SEEK = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP = 2'd2;
    localparam int unsigned ENT_W = EXT_W + 2 * STR_W;

    typedef struct packed {
        logic             start;
        logic [LIN_W-1:0] dividend;
        logic [EXT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [LIN_W-1:0] quotient;
        logic [EXT_W-1:0] remainder;
    } t_div_rsp;
endpackage
`default_nettype wire

// ----- design/nbag_ram.sv -----
`default_nettype none
module nbag_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  wire                                          i_clk,
    input  wire                                          i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                             i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/nbag_div.sv -----
`default_nettype none
module nbag_div
    import nbag_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);
    // restoring divider, one quotient bit per cycle
    localparam int unsigned CW = $clog2(LIN_W + 1);
    logic [LIN_W-1:0] r_q;
    logic [EXT_W:0]   r_r;
    logic [EXT_W-1:0] r_d;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [EXT_W:0]   n_sh;
    logic [EXT_W:0]   n_sub;

    always_comb begin
        n_sh  = {r_r[EXT_W-1:0], r_q[LIN_W-1]};
        n_sub = n_sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(LIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            if (!n_sub[EXT_W]) begin
                r_r <= n_sub;
                r_q <= {r_q[LIN_W-2:0], 1'b1};
            end else begin
                r_r <= n_sh;
                r_q <= {r_q[LIN_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_r[EXT_W-1:0];
endmodule
`default_nettype wire

// ----- design/nd_broadcast_address_generator_core.sv -----
`default_nettype none
// Channel | dir | handshake            | payload
// in      | in  | i_valid / o_ready    | i_op i_dim_index i_extent i_stride_a/b i_linear_index
// out     | out | o_valid / i_ready    | o_addr_a o_addr_b o_rolled_over
// cfg     | in  | i_cfg_we             | i_cfg_wdata (rank)
//
// One word in the datapath at a time; the result register lets the next word
// be accepted while a finished word waits for the consumer.
// Path from acceptance to o_valid: load / unused op go straight to S_OUT; step visits
// S_RD, S_DAT, S_WRAP, (S_MUL, S_MULH where it carries), S_SACC per dimension; seek
// visits S_RD, S_DAT, S_DIV (the 48-step restoring divide), S_MUL, S_MULH, S_ACC per dimension.
// Synchronous reset: rank 1, offsets 0, coordinate valid bits 0, output empty.
// A stalled consumer holds a finished word in S_OUT until the register frees.
module nd_broadcast_address_generator_core
    import nbag_pkg::*;
#(
    parameter int unsigned MAX_DIMS     = 8,
    parameter int unsigned OFFSET_WIDTH = 48
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [RANK_W-1:0]   i_cfg_wdata,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [OP_W-1:0]     i_op,
    input  wire  [DIM_W-1:0]    i_dim_index,
    input  wire  [EXT_W-1:0]    i_extent,
    input  wire  [STR_W-1:0]    i_stride_a,
    input  wire  [STR_W-1:0]    i_stride_b,
    input  wire  [LIN_W-1:0]    i_linear_index,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [OUT_W-1:0]    o_addr_a,
    output logic [OUT_W-1:0]    o_addr_b,
    output logic                o_rolled_over
);
    localparam int unsigned AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned CW  = $clog2(MAX_DIMS + 1);
    localparam int unsigned OW  = OFFSET_WIDTH;
    localparam int unsigned MW  = EXT_W + STR_W;
    localparam int unsigned SLO = STR_W / 2;  // stride split into low and high halves for S_MUL and S_MULH

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // table read issued
    localparam logic [3:0] S_DAT   = 4'd2;  // read data valid
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;  // low stride half product
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_WRAP  = 4'd6;  // step: carry decision
    localparam logic [3:0] S_SACC  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_MULH  = 4'd9;  // high stride half product

    logic [3:0]          r_state;
    logic [RANK_W-1:0]   r_rank;
    logic [OP_W-1:0]     r_op;
    logic [AW-1:0]       r_dim;
    logic [LIN_W-1:0]    r_rem;
    logic [OW-1:0]       r_oa, r_ob;
    logic [OW-1:0]       r_acc_a, r_acc_b;
    logic [EXT_W-1:0]    r_coord;
    logic [EXT_W-1:0]    r_e;
    logic [STR_W-1:0]    r_sa, r_sb;
    logic [MW-1:0]       r_pa, r_pb;
    logic                r_roll;
    logic [MAX_DIMS-1:0] r_cvld;
    logic                r_ovld;

    logic                tab_we;
    logic [AW-1:0]       tab_wa, rd_a;
    logic [ENT_W-1:0]    tab_wd, tab_rd;
    logic                crd_we;
    logic [AW-1:0]       crd_wa;
    logic [EXT_W-1:0]    crd_wd, crd_rd;
    logic [CW-1:0]       active_cnt;
    logic [EXT_W-1:0]    ext_eff;
    logic [EXT_W-1:0]    coord_cur;
    logic [EXT_W-1:0]    mul_x;
    logic [EXT_W+SLO-1:0]       pl_a, pl_b;
    logic [EXT_W+STR_W-SLO-1:0] ph_a, ph_b;
    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic                in_acc;
    logic                out_load;

    nbag_ram #(.WIDTH(ENT_W), .DEPTH(MAX_DIMS)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_wa), .i_wdata(tab_wd),
        .i_raddr(rd_a), .o_rdata(tab_rd));
    nbag_ram #(.WIDTH(EXT_W), .DEPTH(MAX_DIMS)) u_crd (
        .i_clk(i_clk), .i_we(crd_we), .i_waddr(crd_wa), .i_wdata(crd_wd),
        .i_raddr(rd_a), .o_rdata(crd_rd));
    nbag_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // rank 0 acts as 1, rank above the table acts as the table size
    always_comb begin
        if (r_rank == '0) active_cnt = CW'(1);
        else if (32'(r_rank) > MAX_DIMS) active_cnt = CW'(MAX_DIMS);
        else active_cnt = CW'(r_rank);
    end

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign out_load  = (r_state == S_OUT) && (!r_ovld || i_ready);
    assign ext_eff   = (tab_rd[ENT_W-1 -: EXT_W] == '0) ? EXT_W'(1) : tab_rd[ENT_W-1 -: EXT_W];
    assign coord_cur = r_cvld[r_dim] ? crd_rd : '0;
    assign rd_a      = r_dim;

    // seek multiplies the coordinate, a carrying step the extent
    assign mul_x = (r_op == OP_SEEK) ? r_coord : r_e;
    assign pl_a  = mul_x * r_sa[SLO-1:0];
    assign pl_b  = mul_x * r_sb[SLO-1:0];
    assign ph_a  = mul_x * r_sa[STR_W-1:SLO];
    assign ph_b  = mul_x * r_sb[STR_W-1:SLO];

    assign tab_we = in_acc && (i_op == OP_LOAD) && (32'(i_dim_index) < MAX_DIMS);
    assign tab_wa = AW'(i_dim_index);
    assign tab_wd = {i_extent, i_stride_a, i_stride_b};

    always_comb begin
        crd_we = 1'b0;
        crd_wa = r_dim;
        crd_wd = r_coord;
        if (tab_we) begin
            crd_we = 1'b1;
            crd_wa = AW'(i_dim_index);
            crd_wd = '0;
        end else if (r_state == S_ACC || r_state == S_SACC) begin
            crd_we = 1'b1;
        end
    end

    always_comb begin
        div_req.start    = (r_state == S_DAT) && (r_op == OP_SEEK);
        div_req.dividend = r_rem;
        div_req.divisor  = ext_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rank  <= RANK_W'(1);
            r_cvld  <= '0;
            r_ovld  <= 1'b0;
            r_oa    <= '0;
            r_ob    <= '0;
        end else begin
            if (i_cfg_we) r_rank <= i_cfg_wdata;
            if (out_load) r_ovld <= 1'b1;
            else if (o_valid && i_ready) r_ovld <= 1'b0;
            if (out_load) begin
                o_addr_a      <= OUT_W'(r_oa);
                o_addr_b      <= OUT_W'(r_ob);
                o_rolled_over <= (r_op == OP_STEP) && r_roll;
            end
            if (tab_we) r_cvld[AW'(i_dim_index)] <= 1'b1;
            if (crd_we && !tab_we) r_cvld[r_dim] <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_op;
                        r_roll <= 1'b0;
                        r_dim  <= AW'(active_cnt - 1'b1);
                        r_rem  <= i_linear_index;
                        r_acc_a <= '0;
                        r_acc_b <= '0;
                        if (i_op == OP_SEEK || i_op == OP_STEP) begin
                            r_state <= S_RD;
                        end else begin
                            if (tab_we) begin
                                r_oa <= '0;
                                r_ob <= '0;
                            end
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RD: r_state <= S_DAT;
                S_DAT: begin
                    r_e  <= ext_eff;
                    r_sa <= tab_rd[2*STR_W-1 -: STR_W];
                    r_sb <= tab_rd[STR_W-1:0];
                    if (r_op == OP_SEEK) begin
                        r_state <= S_DIV;
                    end else begin
                        r_coord <= coord_cur + 1'b1;
                        r_pa <= '0;
                        r_pb <= '0;
                        r_state <= S_WRAP;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_coord <= div_rsp.remainder;
                        r_rem   <= div_rsp.quotient;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pa <= MW'(pl_a);
                    r_pb <= MW'(pl_b);
                    r_state <= S_MULH;
                end
                S_MULH: begin
                    r_pa <= r_pa + (MW'(ph_a) << SLO);
                    r_pb <= r_pb + (MW'(ph_b) << SLO);
                    r_state <= (r_op == OP_SEEK) ? S_ACC : S_SACC;
                end
                S_ACC: begin
                    r_acc_a <= r_acc_a + OW'(r_pa);
                    r_acc_b <= r_acc_b + OW'(r_pa == r_pa ? r_pb : r_pb);
                    if (r_dim == '0) begin
                        r_oa <= r_acc_a + OW'(r_pa);
                        r_ob <= r_acc_b + OW'(r_pb);
                        r_state <= S_OUT;
                    end else begin
                        r_dim <= r_dim - 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_WRAP: begin
                    // coordinate stays below its extent, so reaching it is the wrap
                    if (r_coord == r_e) begin
                        r_coord <= '0;
                        r_roll  <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_roll  <= 1'b0;
                        r_state <= S_SACC;
                    end
                end
                S_SACC: begin
                    r_oa <= r_oa + OW'(r_sa) - OW'(r_pa);
                    r_ob <= r_ob + OW'(r_sb) - OW'(r_pb);
                    if (r_roll && r_dim != '0) begin
                        r_dim <= r_dim - 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovld;
endmodule
`default_nettype wire

// ----- design/nbag_checker.sv -----
`default_nettype none
module nbag_checker
    import nbag_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_valid,
    input wire              o_ready,
    input wire              o_valid,
    input wire              i_ready,
    input wire [OUT_W-1:0]  o_addr_a,
    input wire [OUT_W-1:0]  o_addr_b,
    input wire              o_rolled_over
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_addr_a) && $stable(o_addr_b)
            && $stable(o_rolled_over)) else $error("out hold");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("busy");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("reset");
    a_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready) else $error("idle after reset");
endmodule

bind nd_broadcast_address_generator_core nbag_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_addr_a(o_addr_a), .o_addr_b(o_addr_b),
    .o_rolled_over(o_rolled_over));
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import nbag_pkg::*;

    localparam int unsigned NDIM = 8;
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // Directed rows: expected offsets typed in only where obvious; the rest uses the predictor.
    typedef struct {
        logic              is_cfg;
        logic [RANK_W-1:0] rank;
        logic [OP_W-1:0]   op;
        logic [DIM_W-1:0]  dim;
        logic [EXT_W-1:0]  ext;
        logic [STR_W-1:0]  sa;
        logic [STR_W-1:0]  sb;
        logic [LIN_W-1:0]  lin;
        logic              has_exp;
        logic [OUT_W-1:0]  exp_a;
        logic [OUT_W-1:0]  exp_b;
        logic              exp_roll;
    } t_row;

    typedef struct packed {
        logic [OUT_W-1:0] off_a;
        logic [OUT_W-1:0] off_b;
        logic             roll;
    } t_addr;

    logic clk, rst_n;
    logic cfg_we;
    logic [RANK_W-1:0] cfg_wdata;
    logic in_valid, in_ready;
    logic [OP_W-1:0] op;
    logic [DIM_W-1:0] dim_index;
    logic [EXT_W-1:0] extent;
    logic [STR_W-1:0] stride_a, stride_b;
    logic [LIN_W-1:0] linear_index;
    logic out_valid, out_ready;
    logic [OUT_W-1:0] off_a, off_b;
    logic rolled;

    nd_broadcast_address_generator_core DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_op(op), .i_dim_index(dim_index), .i_extent(extent),
        .i_stride_a(stride_a), .i_stride_b(stride_b), .i_linear_index(linear_index),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_addr_a(off_a), .o_addr_b(off_b), .o_rolled_over(rolled)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predictor state: shape tables, odometer coordinates, running offsets
    logic [RANK_W-1:0] shape_rank;
    logic [EXT_W-1:0]  shape_ext [NDIM];
    logic [STR_W-1:0]  shape_sa [NDIM];
    logic [STR_W-1:0]  shape_sb [NDIM];
    logic [EXT_W-1:0]  coord [NDIM];
    logic [OUT_W-1:0]  cur_a, cur_b;
    t_addr             pending_addrs[$];
    int                errors, words_out, n_seek, n_step, n_roll;

    function automatic int unsigned live_dims();
        if (shape_rank == 0) return 1;
        if (shape_rank > NDIM) return NDIM;
        return 32'(shape_rank);
    endfunction

    function automatic t_addr predict_addr(logic [OP_W-1:0] o, logic [DIM_W-1:0] d,
                                           logic [EXT_W-1:0] e, logic [STR_W-1:0] sa,
                                           logic [STR_W-1:0] sb, logic [LIN_W-1:0] lin);
        t_addr r;
        logic [63:0] rem, ea, oa, ob, c;
        int n;
        n = live_dims();
        r.roll = 1'b0;
        case (o)
            OP_LOAD: begin
                shape_ext[d] = e;
                shape_sa[d] = sa;
                shape_sb[d] = sb;
                coord[d] = '0;
                cur_a = '0;
                cur_b = '0;
            end
            OP_SEEK: begin
                rem = 64'(lin);
                oa = '0;
                ob = '0;
                for (int k = n - 1; k >= 0; k--) begin
                    ea = (shape_ext[k] == 0) ? 64'd1 : 64'(shape_ext[k]);
                    c = rem % ea;
                    rem = rem / ea;
                    coord[k] = c[EXT_W-1:0];
                    oa += c * 64'(shape_sa[k]);
                    ob += c * 64'(shape_sb[k]);
                end
                cur_a = oa[OUT_W-1:0];
                cur_b = ob[OUT_W-1:0];
            end
            OP_STEP: begin
                oa = 64'(cur_a);
                ob = 64'(cur_b);
                r.roll = 1'b1;
                for (int k = n - 1; k >= 0; k--) begin
                    ea = (shape_ext[k] == 0) ? 64'd1 : 64'(shape_ext[k]);
                    c = 64'(coord[k]) + 1;
                    oa += 64'(shape_sa[k]);
                    ob += 64'(shape_sb[k]);
                    if (c < ea) begin
                        coord[k] = c[EXT_W-1:0];
                        r.roll = 1'b0;
                        break;
                    end
                    coord[k] = '0;
                    oa -= 64'(shape_sa[k]) * ea;
                    ob -= 64'(shape_sb[k]) * ea;
                end
                cur_a = oa[OUT_W-1:0];
                cur_b = ob[OUT_W-1:0];
            end
            default: ;
        endcase
        r.off_a = cur_a;
        r.off_b = cur_b;
        return r;
    endfunction

    // Sender: one word, with the predictor updated at acceptance
    task automatic send_word(logic [OP_W-1:0] o, logic [DIM_W-1:0] d, logic [EXT_W-1:0] e,
                             logic [STR_W-1:0] sa, logic [STR_W-1:0] sb,
                             logic [LIN_W-1:0] lin, bit typed, t_addr typed_exp);
        t_addr p;
        in_valid <= 1'b1;
        op <= o;
        dim_index <= d;
        extent <= e;
        stride_a <= sa;
        stride_b <= sb;
        linear_index <= lin;
        do @(posedge clk); while (!in_ready);
        p = predict_addr(o, d, e, sa, sb, lin);
        if (o == OP_SEEK) n_seek++;
        if (o == OP_STEP) n_step++;
        if (typed && p !== typed_exp) begin
            $error("directed row: predictor gives %h, table says %h", p, typed_exp);
            errors++;
        end
        pending_addrs.push_back(typed ? typed_exp : p);
    endtask

    // Burst/gap pacing: gaps land between words, never under a held valid
    int burst_left;
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(0, 12);
    endtask

    task automatic drain_and_set_rank(logic [RANK_W-1:0] r);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_addrs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        shape_rank = r;
    endtask

    // Receiver: stalls follow a rotating mask, with stall-free stretches
    logic [15:0] stall_mask;
    int stall_phase;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (out_valid && out_ready) begin
                words_out++;
                if (pending_addrs.size() == 0) begin
                    $error("unexpected output word a=%h b=%h", off_a, off_b);
                    errors++;
                end else begin
                    t_addr x;
                    x = pending_addrs.pop_front();
                    if (off_a !== x.off_a) begin
                        $error("addr_a expected %h actual %h", x.off_a, off_a);
                        errors++;
                    end
                    if (off_b !== x.off_b) begin
                        $error("addr_b expected %h actual %h", x.off_b, off_b);
                        errors++;
                    end
                    if (rolled !== x.roll) begin
                        $error("rolled_over expected %b actual %b", x.roll, rolled);
                        errors++;
                    end
                    if (x.roll) n_roll++;
                end
            end
            stall_phase <= stall_phase + 1;
            if (stall_phase[9]) out_ready <= 1'b1;
            else out_ready <= stall_mask[stall_phase[3:0]];
        end
    end

    t_row rows[$];

    function automatic t_row mk(logic [OP_W-1:0] o, logic [DIM_W-1:0] d, logic [EXT_W-1:0] e,
                                logic [STR_W-1:0] sa, logic [STR_W-1:0] sb,
                                logic [LIN_W-1:0] lin);
        t_row r;
        r = '{default: '0};
        r.op = o; r.dim = d; r.ext = e; r.sa = sa; r.sb = sb; r.lin = lin;
        return r;
    endfunction

    function automatic t_row mkx(t_row r, logic [OUT_W-1:0] a, logic [OUT_W-1:0] b, logic rl);
        r.has_exp = 1; r.exp_a = a; r.exp_b = b; r.exp_roll = rl;
        return r;
    endfunction

    function automatic t_row mkcfg(logic [RANK_W-1:0] r);
        t_row x;
        x = '{default: '0};
        x.is_cfg = 1; x.rank = r;
        return x;
    endfunction

    task automatic load_random_shape(bit tiny);
        for (int d = 0; d < NDIM; d++) begin
            logic [EXT_W-1:0] e;
            logic [STR_W-1:0] sa, sb;
            pace();
            case ($urandom_range(0, 9))
                0: e = '0;
                1: e = '1;
                2: e = $urandom;
                default: e = tiny ? $urandom_range(1, 4) : $urandom_range(1, 9);
            endcase
            sa = ($urandom_range(0, 3) == 0) ? '0 : 40'({$urandom, $urandom});
            sb = ($urandom_range(0, 3) == 0) ? '0 : 40'({$urandom, $urandom});
            if ($urandom_range(0, 2) == 0) sa = 40'($urandom_range(1, 64));
            send_word(OP_LOAD, d[DIM_W-1:0], e, sa, sb, '0, 0, '0);
        end
    endtask

    initial begin
        t_addr te;
        int deadline;
        errors = 0; words_out = 0; n_seek = 0; n_step = 0; n_roll = 0;
        burst_left = 0;
        stall_mask = 16'hB5E3;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_wdata = 4'd1;
        in_valid = 1'b0; op = OP_LOAD; dim_index = '0; extent = '0;
        stride_a = '0; stride_b = '0; linear_index = '0;
        shape_rank = 4'd1;
        cur_a = '0; cur_b = '0;
        for (int d = 0; d < NDIM; d++) begin
            coord[d] = '0; shape_ext[d] = '0;
            shape_sa[d] = '0; shape_sb[d] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, unused op, extremes, zero extent, rank 0 and rank 15
        rows.push_back(mkx(mk(OP_NOP, 3'd0, '0, '0, '0, '0), '0, '0, 1'b0));
        rows.push_back(mkx(mk(OP_LOAD, 3'd0, 32'd3, 40'd5, 40'd7, '0), '0, '0, 1'b0));
        rows.push_back(mkx(mk(OP_STEP, 3'd0, '0, '0, '0, '0), 48'd5, 48'd7, 1'b0));
        rows.push_back(mkx(mk(OP_STEP, 3'd0, '0, '0, '0, '0), 48'd10, 48'd14, 1'b0));
        rows.push_back(mkx(mk(OP_STEP, 3'd0, '0, '0, '0, '0), '0, '0, 1'b1));
        rows.push_back(mkx(mk(OP_SEEK, 3'd0, '0, '0, '0, 48'd5), 48'd10, 48'd14, 1'b0));
        rows.push_back(mk(OP_SEEK, 3'd0, '0, '0, '0, '1));
        rows.push_back(mkx(mk(OP_LOAD, 3'd0, '0, '1, '1, '1), '0, '0, 1'b0));
        rows.push_back(mkx(mk(OP_STEP, 3'd0, '0, '0, '0, '0), '0, '0, 1'b1));
        rows.push_back(mk(OP_LOAD, 3'd0, '1, '1, '1, '0));
        rows.push_back(mk(OP_SEEK, 3'd0, '0, '0, '0, '1));
        rows.push_back(mk(OP_STEP, 3'd0, '0, '0, '0, '0));
        rows.push_back(mk(OP_NOP, 3'd7, '1, '1, '1, '1));
        for (int d = 1; d < NDIM; d++)
            rows.push_back(mk(OP_LOAD, d[DIM_W-1:0], 32'd2, 40'(d * 3), '1, '0));
        rows.push_back(mkcfg(4'd0));
        rows.push_back(mk(OP_STEP, 3'd0, '0, '0, '0, '0));
        rows.push_back(mkcfg(4'd15));
        rows.push_back(mk(OP_SEEK, 3'd0, '0, '0, '0, 48'hABCDE));
        rows.push_back(mk(OP_STEP, 3'd0, '0, '0, '0, '0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) drain_and_set_rank(rows[i].rank);
            else begin
                te.off_a = rows[i].exp_a; te.off_b = rows[i].exp_b; te.roll = rows[i].exp_roll;
                send_word(rows[i].op, rows[i].dim, rows[i].ext, rows[i].sa, rows[i].sb,
                          rows[i].lin, rows[i].has_exp, te);
            end
        end

        // Random phases: each picks a rank, reloads the shape, then mostly steps and seeks
        for (int ph = 0; ph < 10; ph++) begin
            logic [RANK_W-1:0] rk;
            rk = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd8 : 4'($urandom_range(0, 15));
            drain_and_set_rank(rk);
            load_random_shape(ph % 2 == 1);
            for (int i = 0; i < 42; i++) begin
                int pick;
                pace();
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    send_word(OP_STEP, 3'($urandom), $urandom, '0, '0, '0, 0, '0);
                else if (pick < 16)
                    send_word(OP_SEEK, 3'($urandom), $urandom, '0, '0,
                              ($urandom_range(0, 1) != 0) ? 48'($urandom_range(0, 300))
                                                          : 48'({$urandom, $urandom}),
                              0, '0);
                else if (pick < 18)
                    send_word(OP_LOAD, 3'($urandom_range(0, NDIM - 1)),
                              $urandom_range(0, 5), 40'({$urandom, $urandom}),
                              40'({$urandom, $urandom}), 48'({$urandom, $urandom}), 0, '0);
                else
                    send_word(OP_NOP, 3'($urandom), $urandom, 40'({$urandom, $urandom}),
                              40'({$urandom, $urandom}), 48'({$urandom, $urandom}), 0, '0);
            end
        end
        in_valid <= 1'b0;

        deadline = 0;
        while (pending_addrs.size() != 0 && deadline < 200000) begin
            @(posedge clk);
            deadline++;
        end
        repeat (500) @(posedge clk);
        if (pending_addrs.size() != 0) begin
            $error("%0d expected words never arrived", pending_addrs.size());
            errors++;
        end
        $display("covered %0d output words: %0d seeks, %0d steps, %0d full rollovers",
                 words_out, n_seek, n_step, n_roll);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // Worst case ~600 words, each up to a rank-8 seek, plus stalls
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
design/nbag_pkg.sv
design/nbag_ram.sv
design/nbag_div.sv
design/nd_broadcast_address_generator_core.sv
design/nbag_checker.sv
tb/testbench.sv
